// ===== hw/rtl/wc3_pkg.sv =====
// Shared constants, register codes and payload types of the 3x3 window convolution block.
package wc3_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int IMG_W     = 11;
    localparam int MASK_W    = 24;
    localparam int COEF_W    = 8;
    localparam int FILT_W    = 15;
    localparam int ROW_OUT_W = 12;
    localparam int COL_OUT_W = 10;

    // Narrowest usable row width
    localparam int WIDTH_MIN = 3;

    // Queue depths between the parts
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // Arithmetic widths of the back end
    localparam int PROD_W = PIX_W + COEF_W + 1;   // unsigned pixel times signed coefficient
    localparam int RSUM_W = PROD_W + 2;           // three products
    localparam int TSUM_W = RSUM_W + 2;           // three row sums
    localparam int POS_W  = 19;                   // clamped sum stays below 2**19

    // Divide by nine as multiply by ceil(2**23 / 9), exact for sums below 2**21
    localparam int                RECIP_SHIFT = 23;
    localparam int                RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_9    = 20'd932068;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH = 2'b00,
        REG_MASK_TOP    = 2'b01,
        REG_MASK_MID    = 2'b10,
        REG_MASK_BOT    = 2'b11
    } cfg_index_t;

    // Window pixels: [row][column][bit], row 0 on top, column 0 on the left
    typedef logic [2:0][2:0][PIX_W-1:0] pix_window_t;

    typedef struct packed {
        pix_window_t          win;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
    } window_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] top;
        logic [MASK_W-1:0] mid;
        logic [MASK_W-1:0] bot;
    } mask_set_t;

    typedef struct packed {
        logic [FILT_W-1:0]    filtered;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
    } result_t;

endpackage

// ===== hw/rtl/wc3_queue.sv =====
// Small register-based first-in first-out queue with a fill level output.
module wc3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             din,
    input  logic                         pop,
    output logic [WIDTH-1:0]             dout,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_pop;

    // Drop a pop request against an empty queue
    assign do_pop = pop && (level_reg != '0);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        level_next = level_reg + LW'(push) - LW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

    // Writers reserve room ahead, so a push never meets a full queue
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg < LW'(DEPTH)))
        else $error("queue pushed while full");

endmodule

// ===== hw/rtl/wc3_front.sv =====
// Front end: pixel intake, row and column tracking, line store and 3x3 window.
module wc3_front #(
    parameter int MAX_WIDTH  = wc3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wc3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       push,
    input  logic [wc3_pkg::PIX_W-1:0]                  pixel,
    input  logic                                       frame_start,
    output logic                                       full,
    input  logic [wc3_pkg::IMG_W-1:0]                  image_width,
    input  logic [$clog2(wc3_pkg::MID_DEPTH+1)-1:0]    q_level,
    output logic                                       q_push,
    output wc3_pkg::window_item_t                      q_item
);

    import wc3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > IMG_W) ? CW + 1 : IMG_W;

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic              stop_reg, stop_next;

    logic [CW-1:0]     col_cur, col_c;
    logic [RW-1:0]     row_cur;
    logic              stop_cur;
    logic [WW-1:0]     img_ext, width_eff, col_plus;
    logic              wrap, accept, take, produce;
    logic [31:0]       row_m2, col_m2;

    logic [PIX_W-1:0]  bank0 [MAX_WIDTH];
    logic [PIX_W-1:0]  bank1 [MAX_WIDTH];
    logic [PIX_W-1:0]  rd0_reg, rd1_reg;

    logic                 s1_valid_reg;
    logic                 s1_produce_reg;
    logic                 s1_odd_reg;
    logic [PIX_W-1:0]     s1_px_reg;
    logic [ROW_OUT_W-1:0] s1_row_reg;
    logic [COL_OUT_W-1:0] s1_col_reg;

    pix_window_t       win_reg, win_next;

    // Hold new requests while the queue may not take the one in flight
    assign full   = (32'(q_level) + 32'(s1_valid_reg)) >= 32'(MID_DEPTH);
    assign accept = push && !full;

    // Position of the incoming pixel, after an optional frame restart
    always_comb
    begin
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        stop_cur = !frame_start && stop_reg;
        col_c    = (32'(col_cur) > 32'(MAX_WIDTH - 1)) ? CW'(MAX_WIDTH - 1) : col_cur;

        img_ext = WW'(image_width);
        if (img_ext < WW'(WIDTH_MIN))
        begin
            width_eff = WW'(WIDTH_MIN);
        end
        else if (img_ext > WW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = img_ext;
        end

        col_plus = WW'(col_c) + WW'(1);
        wrap     = col_plus >= width_eff;
        take     = accept && !stop_cur;
        produce  = (row_cur >= RW'(2)) && (col_c >= CW'(2));
        row_m2   = 32'(row_cur) - 32'd2;
        col_m2   = 32'(col_c) - 32'd2;
    end

    // Advance column and row; stop the frame after its last allowed row
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        stop_next = stop_reg;
        if (accept)
        begin
            col_next  = col_cur;
            row_next  = row_cur;
            stop_next = stop_cur;
            if (!stop_cur)
            begin
                if (wrap)
                begin
                    col_next = '0;
                    if (row_cur == RW'(MAX_HEIGHT - 1))
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_cur + RW'(1);
                    end
                end
                else
                begin
                    col_next = col_plus[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            stop_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            stop_reg     <= stop_next;
            s1_valid_reg <= take;
            win_reg      <= win_next;
        end
    end

    // Line store: bank of the row parity holds row r-2, the other row r-1
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd0_reg <= bank0[col_c];
            rd1_reg <= bank1[col_c];
            if (!row_cur[0])
            begin
                bank0[col_c] <= pixel;
            end
            else
            begin
                bank1[col_c] <= pixel;
            end
        end
    end

    // Carry the pixel and its window position alongside the store read
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_produce_reg <= produce;
            s1_odd_reg     <= row_cur[0];
            s1_px_reg      <= pixel;
            s1_row_reg     <= row_m2[ROW_OUT_W-1:0];
            s1_col_reg     <= col_m2[COL_OUT_W-1:0];
        end
    end

    // Shift the window left and load the new right column
    always_comb
    begin
        win_next = win_reg;
        if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = s1_odd_reg ? rd1_reg : rd0_reg;
            win_next[1][2] = s1_odd_reg ? rd0_reg : rd1_reg;
            win_next[2][2] = s1_px_reg;
        end
    end

    // Hand a complete window to the back end
    assign q_push     = s1_valid_reg && s1_produce_reg;
    assign q_item.win = win_next;
    assign q_item.row = s1_row_reg;
    assign q_item.col = s1_col_reg;

    // A window leaves only in the cycle after its pixel was taken
    a_push_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> $past(take))
        else $error("window pushed without a pixel taken");

endmodule

// ===== hw/rtl/wc3_back.sv =====
// Back end: nine products, summation, clamp and divide by nine.
module wc3_back (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       q_empty,
    input  wc3_pkg::window_item_t                      q_item,
    output logic                                       q_pop,
    input  wc3_pkg::mask_set_t                         masks,
    input  logic [$clog2(wc3_pkg::OUT_DEPTH+1)-1:0]    out_level,
    output logic                                       out_push,
    output wc3_pkg::result_t                           out_item
);

    import wc3_pkg::*;

    localparam int MUL_W = POS_W + RECIP_W;

    logic [2:0][MASK_W-1:0] mask_rows;
    logic [31:0]            in_flight;

    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PROD_W-1:0]   prod_reg [3][3];
    logic signed [RSUM_W-1:0]   rsum_reg [3];
    logic [POS_W-1:0]           pos_reg;
    logic signed [TSUM_W-1:0]   total;
    logic [MUL_W-1:0]           scaled;

    logic [ROW_OUT_W-1:0] row1_reg, row2_reg, row3_reg;
    logic [COL_OUT_W-1:0] col1_reg, col2_reg, col3_reg;
    result_t              res_reg;

    assign mask_rows[0] = masks.top;
    assign mask_rows[1] = masks.mid;
    assign mask_rows[2] = masks.bot;

    // Take a window only when the result queue has room for all in flight
    assign in_flight = 32'(v1_reg) + 32'(v2_reg) + 32'(v3_reg) + 32'(v4_reg);
    assign q_pop     = !q_empty && ((32'(out_level) + in_flight) < 32'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= q_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: multiply each pixel by the coefficient in the same place
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed({1'b0, q_item.win[i][j]})
                                    * $signed(mask_rows[i][COEF_W*j +: COEF_W]);
                end
            end
            row1_reg <= q_item.row;
            col1_reg <= q_item.col;
        end
    end

    // Stage 2: sum each mask row
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsum_reg[i] <= {{2{prod_reg[i][0][PROD_W-1]}}, prod_reg[i][0]}
                             + {{2{prod_reg[i][1][PROD_W-1]}}, prod_reg[i][1]}
                             + {{2{prod_reg[i][2][PROD_W-1]}}, prod_reg[i][2]};
            end
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
        end
    end

    // Stage 3: total the rows and clamp negatives to zero
    always_comb
    begin
        total = {{2{rsum_reg[0][RSUM_W-1]}}, rsum_reg[0]}
              + {{2{rsum_reg[1][RSUM_W-1]}}, rsum_reg[1]}
              + {{2{rsum_reg[2][RSUM_W-1]}}, rsum_reg[2]};
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            pos_reg  <= (total > 0) ? total[POS_W-1:0] : '0;
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
        end
    end

    // Stage 4: divide by nine through the reciprocal
    assign scaled = MUL_W'(pos_reg) * MUL_W'(RECIP_9);

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            res_reg.filtered <= scaled[RECIP_SHIFT +: FILT_W];
            res_reg.row      <= row3_reg;
            res_reg.col      <= col3_reg;
        end
    end

    assign out_push = v4_reg;
    assign out_item = res_reg;

    // A result leaves after its window passes the product, row sum, clamped sum and result registers
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> $past(q_pop, 4))
        else $error("result without a matching window");

    // Reserved room never exceeds the result queue
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(out_level) + in_flight) <= 32'(OUT_DEPTH))
        else $error("result queue overcommitted");

endmodule

// ===== hw/rtl/window_convolution_3x3.sv =====
// Top level of the 3x3 window convolution: configuration registers, front end, queues, back end.
//
//  channel   direction  request taken when        payload
//  ------    ---------  ------------------------  ---------------------------------
//  input     in         push && !full             pixel, frame_start
//  result    out        pop && !empty             filtered, out_row, out_col
//  config    in         cfg_write                 cfg_index, cfg_data
//
//  One pixel per clock sustained while full stays low; a result reaches the result ports
//  from the edge that takes its pixel through the line store read, the window queue, the
//  multiply, sum, clamp and divide pipeline and the result queue; an empty one adds no wait.
//  Reset clears counters, window and queues at once; the line store needs no clearing.
//  full rises only when a stalled pop leaves the window queue no room for the window in flight.
module window_convolution_3x3 #(
    parameter int MAX_WIDTH  = wc3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wc3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [wc3_pkg::PIX_W-1:0]        pixel,
    input  logic                             frame_start,
    output logic                             empty,
    input  logic                             pop,
    output logic [wc3_pkg::FILT_W-1:0]       filtered,
    output logic [wc3_pkg::ROW_OUT_W-1:0]    out_row,
    output logic [wc3_pkg::COL_OUT_W-1:0]    out_col,
    input  logic                             cfg_write,
    input  wc3_pkg::cfg_index_t              cfg_index,
    input  logic [wc3_pkg::MASK_W-1:0]       cfg_data
);

    import wc3_pkg::*;

    logic [IMG_W-1:0] image_width_reg;
    mask_set_t        masks_reg;

    logic                             mid_push, mid_pop, mid_empty;
    window_item_t                     mid_din, mid_dout;
    logic [$clog2(MID_DEPTH+1)-1:0]   mid_level;

    logic                             res_push;
    result_t                          res_din, res_dout;
    logic [$clog2(OUT_DEPTH+1)-1:0]   res_level;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMG_W'(640);
            masks_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMG_W-1:0];
                REG_MASK_TOP:    masks_reg.top   <= cfg_data;
                REG_MASK_MID:    masks_reg.mid   <= cfg_data;
                REG_MASK_BOT:    masks_reg.bot   <= cfg_data;
            endcase
        end
    end

    wc3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pixel       (pixel),
        .frame_start (frame_start),
        .full        (full),
        .image_width (image_width_reg),
        .q_level     (mid_level),
        .q_push      (mid_push),
        .q_item      (mid_din)
    );

    wc3_queue #(
        .WIDTH ($bits(window_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_din),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty),
        .level (mid_level)
    );

    wc3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (mid_empty),
        .q_item    (mid_dout),
        .q_pop     (mid_pop),
        .masks     (masks_reg),
        .out_level (res_level),
        .out_push  (res_push),
        .out_item  (res_din)
    );

    wc3_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_din),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty),
        .level (res_level)
    );

    assign filtered = res_dout.filtered;
    assign out_row  = res_dout.row;
    assign out_col  = res_dout.col;

endmodule
